### rtl/lcs_pkg.sv
// Shared types, widths and the heading table of the camera stepper.
package lcs_pkg;

    localparam int PosW  = 32;   // Q16.16 coordinate
    localparam int UnitW = 18;   // Q1.16 vector component
    localparam int VelW  = 24;   // Q8.16 velocity
    localparam int VecW  = 38;   // raw vector component fed to the normalizer
    localparam int CrsW  = 37;   // raw cross product component
    localparam int AccW  = 34;   // move accumulator
    localparam int CfgIdxW = 3;
    localparam int CfgDatW = 32;

    typedef logic signed [VecW-1:0]  vec_t;
    typedef logic signed [UnitW-1:0] unit_t;
    typedef logic signed [PosW-1:0]  pos_t;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_VELOCITY = 3'd0,
        REG_LOOK_X   = 3'd1,
        REG_LOOK_Y   = 3'd2,
        REG_LOOK_Z   = 3'd3,
        REG_UP_X     = 3'd4,
        REG_UP_Y     = 3'd5,
        REG_UP_Z     = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        COEF_ZERO  = 2'd0,
        COEF_PLUS  = 2'd1,
        COEF_MINUS = 2'd2
    } coef_t;

    localparam logic [3:0] HeadCount = 4'd14;

    // normalizer handshake status
    typedef struct packed {
        logic busy;
        logic done;
        logic degen;
    } unit_stat_t;

    // coefficient of term (0 up, 1 direction, 2 right) for a heading
    function automatic coef_t head_coef(input logic [3:0] head, input logic [1:0] term);
        coef_t c_up, c_dir, c_rt;
        c_up  = COEF_ZERO;
        c_dir = COEF_ZERO;
        c_rt  = COEF_ZERO;
        case (head)
            4'd0:  begin c_up = COEF_PLUS;  c_rt = COEF_PLUS;  end
            4'd1:  begin c_up = COEF_PLUS;  c_rt = COEF_MINUS; end
            4'd2:  begin c_up = COEF_MINUS; c_rt = COEF_PLUS;  end
            4'd3:  begin c_up = COEF_MINUS; c_rt = COEF_MINUS; end
            4'd4:  begin c_dir = COEF_PLUS;  c_rt = COEF_PLUS;  end
            4'd5:  begin c_dir = COEF_PLUS;  c_rt = COEF_MINUS; end
            4'd6:  begin c_dir = COEF_MINUS; c_rt = COEF_PLUS;  end
            4'd7:  begin c_dir = COEF_MINUS; c_rt = COEF_MINUS; end
            4'd8:  c_up  = COEF_PLUS;
            4'd9:  c_up  = COEF_MINUS;
            4'd10: c_dir = COEF_PLUS;
            4'd11: c_dir = COEF_MINUS;
            4'd12: c_rt  = COEF_PLUS;
            4'd13: c_rt  = COEF_MINUS;
            default: c_up = COEF_ZERO;
        endcase
        case (term)
            2'd0:    return c_up;
            2'd1:    return c_dir;
            2'd2:    return c_rt;
            default: return COEF_ZERO;
        endcase
    endfunction

endpackage

### rtl/lcs_unitize.sv
// Iterative vector normalizer: scale, sum of squares, bitwise root, bitwise divide.
module lcs_unitize (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  lcs_pkg::vec_t       vin [3],
    output lcs_pkg::unit_t      vout [3],
    output lcs_pkg::unit_stat_t stat
);

    typedef enum logic [2:0] {
        U_IDLE, U_NORM, U_SQ, U_ROOT, U_DIVLD, U_DIV, U_DONE
    } ustate_t;

    ustate_t state_reg, state_next;
    logic [lcs_pkg::VecW-1:0] mag_reg [3];
    logic [lcs_pkg::VecW-1:0] mag_next [3];
    logic [2:0]  neg_reg, neg_next;
    logic [61:0] sum_reg, sum_next;
    logic [61:0] rad_reg, rad_next;      // remaining radicand
    logic [62:0] root_reg, root_next;
    logic [62:0] bit_reg, bit_next;
    logic [30:0] rem_reg, rem_next;
    logic [16:0] nq_reg, nq_next;        // numerator low bits out, quotient in
    logic [4:0]  cnt_reg, cnt_next;
    logic [1:0]  idx_reg, idx_next;
    logic        degen_reg, degen_next;
    lcs_pkg::unit_t o_reg [3];
    lcs_pkg::unit_t o_next [3];

    logic        any_hi, any_top, all_zero;
    logic [59:0] sq;
    logic [63:0] rb;
    logic [30:0] len;
    logic [46:0] num;
    logic [32:0] trial;
    logic [16:0] qv;

    assign len = root_reg[30:0];

    always_comb begin
        any_hi   = 1'b0;
        any_top  = 1'b0;
        all_zero = 1'b1;
        for (int i = 0; i < 3; i++) begin
            any_hi   = any_hi | (|mag_reg[i][lcs_pkg::VecW-1:30]);
            any_top  = any_top | mag_reg[i][29];
            all_zero = all_zero & (mag_reg[i] == '0);
        end
    end

    assign sq    = 60'(mag_reg[idx_reg][29:0]) * 60'(mag_reg[idx_reg][29:0]);
    assign rb    = 64'(root_reg) + 64'(bit_reg);
    assign num   = {1'b0, mag_reg[idx_reg][29:0], 16'd0} + 47'(len[30:1]);
    assign trial = {1'b0, rem_reg, nq_reg[16]} - {2'b00, len};
    assign qv    = {nq_reg[15:0], ~trial[32]};

    always_comb begin
        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        sum_next   = sum_reg;
        rad_next   = rad_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        nq_next    = nq_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        degen_next = degen_reg;
        o_next     = o_reg;
        case (state_reg)
            U_IDLE: begin
                if (start) begin
                    for (int i = 0; i < 3; i++) begin
                        neg_next[i] = vin[i][lcs_pkg::VecW-1];
                        mag_next[i] = vin[i][lcs_pkg::VecW-1] ? (~vin[i] + 1'b1) : vin[i];
                    end
                    state_next = U_NORM;
                end
            end
            U_NORM: begin
                // one bit a cycle until the largest magnitude sits in [2^29, 2^30)
                if (all_zero) begin
                    for (int i = 0; i < 3; i++) o_next[i] = '0;
                    degen_next = 1'b1;
                    state_next = U_DONE;
                end else if (any_hi) begin
                    for (int i = 0; i < 3; i++) mag_next[i] = mag_reg[i] >> 1;
                end else if (!any_top) begin
                    for (int i = 0; i < 3; i++) mag_next[i] = mag_reg[i] << 1;
                end else begin
                    sum_next   = '0;
                    idx_next   = '0;
                    state_next = U_SQ;
                end
            end
            U_SQ: begin
                sum_next = sum_reg + 62'(sq);
                if (idx_reg == 2'd2) begin
                    rad_next   = sum_next;
                    root_next  = '0;
                    bit_next   = 63'd1 << 62;
                    cnt_next   = '0;
                    state_next = U_ROOT;
                end else begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            U_ROOT: begin
                if (64'(rad_reg) >= rb) begin
                    rad_next  = rad_reg - rb[61:0];
                    root_next = (root_reg >> 1) + bit_reg;
                end else begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    idx_next   = '0;
                    state_next = U_DIVLD;
                end
            end
            U_DIVLD: begin
                // quotient never exceeds 65536, so the upper part is already below len
                rem_next   = {1'b0, num[46:17]};
                nq_next    = num[16:0];
                cnt_next   = '0;
                state_next = U_DIV;
            end
            U_DIV: begin
                if (!trial[32]) rem_next = trial[30:0];
                else            rem_next = {rem_reg[29:0], nq_reg[16]};
                nq_next  = qv;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd16) begin
                    o_next[idx_reg] = neg_reg[idx_reg] ? -$signed({1'b0, qv})
                                                       : $signed({1'b0, qv});
                    if (idx_reg == 2'd2) begin
                        degen_next = 1'b0;
                        state_next = U_DONE;
                    end else begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = U_DIVLD;
                    end
                end
            end
            U_DONE:  state_next = U_IDLE;
            default: state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            degen_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            degen_reg <= degen_next;
        end
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        sum_reg  <= sum_next;
        rad_reg  <= rad_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        rem_reg  <= rem_next;
        nq_reg   <= nq_next;
        cnt_reg  <= cnt_next;
        idx_reg  <= idx_next;
        o_reg    <= o_next;
    end

    assign vout       = o_reg;
    assign stat.busy  = (state_reg != U_IDLE);
    assign stat.done  = (state_reg == U_DONE);
    assign stat.degen = degen_reg;

endmodule

### rtl/lookat_camera_stepper.sv
// Top level: camera position, frame sequencer, shared multiplier and result register.
//
//  port group  dir  contents
//  s_*         in   step item: tuser = func, tdata = heading/new position
//  m_*         out  result item: tdata = position/dir/right, tuser = degenerate
//  cfg_*       in   register write: cfg_index selects, cfg_data carries value
//
// Steps: one normalization makes S scaling shifts (S = 0..29), 3 squares, 32 root
// steps and 3 x 18 divide steps; a frame is two of them plus 6 cross product
// steps on the shared multiplier. Load and no-move items take one frame, moves
// two frames with 9 multiply steps between them.
// Reset (aresetn low, synchronous) restores registers and zeroes the position.
// s_tready is high only while idle; a finished result waits in the output
// register, and the block holds there while m_tvalid is high and m_tready low.
module lookat_camera_stepper (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // heading[3:0], new_x[35:4], new_y[67:36], new_z[99:68]
    input  logic         s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [207:0] m_tdata,   // pos_x..z (32 b), dir_x..z, right_x..z (18 b each)
    output logic         m_tuser,   // degenerate
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIR_GO, ST_DIR_WAIT, ST_CROSS,
        ST_RIGHT_GO, ST_RIGHT_WAIT, ST_MOVE, ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    lcs_pkg::pos_t  pos_reg [3];
    lcs_pkg::pos_t  pos_next [3];
    lcs_pkg::pos_t  look_reg [3];
    lcs_pkg::unit_t up_reg [3];
    logic [lcs_pkg::VelW-1:0] vel_reg;
    lcs_pkg::unit_t dir_reg [3];
    lcs_pkg::unit_t dir_next [3];
    lcs_pkg::unit_t right_reg [3];
    lcs_pkg::unit_t right_next [3];
    logic signed [lcs_pkg::CrsW-1:0] crs_reg [3];
    logic signed [lcs_pkg::CrsW-1:0] crs_next [3];
    logic signed [lcs_pkg::AccW-1:0] acc_reg, acc_next;
    logic [3:0] head_reg, head_next;
    logic       first_reg, first_next;
    logic       dg_reg, dg_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] axis_reg, axis_next;
    logic       mval_reg, mval_next;
    logic [207:0] mdata_reg, mdata_next;
    logic       muser_reg, muser_next;

    lcs_pkg::vec_t      u_vin [3];
    lcs_pkg::unit_t     u_vout [3];
    lcs_pkg::unit_stat_t u_stat;
    logic               u_start;

    logic signed [24:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [42:0] prod;
    logic signed [25:0] rnd;
    logic signed [lcs_pkg::AccW-1:0] acc_base, acc_sum;
    lcs_pkg::coef_t coef;
    logic [1:0] d_sel, u_sel;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vel_reg  <= 24'd65536;
            look_reg <= '{default: '0};
            up_reg   <= '{18'sd0, 18'sd65536, 18'sd0};
        end else if (cfg_valid) begin
            case (lcs_pkg::cfg_reg_t'(cfg_index))
                lcs_pkg::REG_VELOCITY: vel_reg     <= cfg_data[23:0];
                lcs_pkg::REG_LOOK_X:   look_reg[0] <= cfg_data;
                lcs_pkg::REG_LOOK_Y:   look_reg[1] <= cfg_data;
                lcs_pkg::REG_LOOK_Z:   look_reg[2] <= cfg_data;
                lcs_pkg::REG_UP_X:     up_reg[0]   <= cfg_data[17:0];
                lcs_pkg::REG_UP_Y:     up_reg[1]   <= cfg_data[17:0];
                lcs_pkg::REG_UP_Z:     up_reg[2]   <= cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // normalizer input: look-at offset or cross product
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (state_reg == ST_RIGHT_GO)
                u_vin[i] = {crs_reg[i][lcs_pkg::CrsW-1], crs_reg[i]};
            else
                u_vin[i] = {{6{look_reg[i][31]}}, look_reg[i]} - {{6{pos_reg[i][31]}}, pos_reg[i]};
        end
    end
    assign u_start = (state_reg == ST_DIR_GO) || (state_reg == ST_RIGHT_GO);

    lcs_unitize u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (u_start),
        .vin     (u_vin),
        .vout    (u_vout),
        .stat    (u_stat)
    );

    // cross product operand pairs: c0 = d1*u2 - d2*u1, c1 = d2*u0 - d0*u2, c2 = d0*u1 - d1*u0
    always_comb begin
        case (cnt_reg)
            3'd0:    begin d_sel = 2'd1; u_sel = 2'd2; end
            3'd1:    begin d_sel = 2'd2; u_sel = 2'd1; end
            3'd2:    begin d_sel = 2'd2; u_sel = 2'd0; end
            3'd3:    begin d_sel = 2'd0; u_sel = 2'd2; end
            3'd4:    begin d_sel = 2'd0; u_sel = 2'd1; end
            3'd5:    begin d_sel = 2'd1; u_sel = 2'd0; end
            default: begin d_sel = 2'd0; u_sel = 2'd0; end
        endcase
    end

    // shared multiplier: cross terms or velocity times a vector component
    always_comb begin
        if (state_reg == ST_MOVE) begin
            mul_a = {1'b0, vel_reg};
            case (cnt_reg[1:0])
                2'd0:    mul_b = up_reg[axis_reg];
                2'd1:    mul_b = dir_reg[axis_reg];
                default: mul_b = right_reg[axis_reg];
            endcase
        end else begin
            mul_a = 25'(dir_reg[d_sel]);
            mul_b = up_reg[u_sel];
        end
    end
    assign prod = 43'(mul_a) * 43'(mul_b);

    // round half up to Q16.16
    assign rnd      = 26'((prod + 43'sd32768) >>> 16);
    assign coef     = lcs_pkg::head_coef(head_reg, cnt_reg[1:0]);
    assign acc_base = (cnt_reg == 3'd0) ? lcs_pkg::AccW'(pos_reg[axis_reg]) : acc_reg;
    always_comb begin
        case (coef)
            lcs_pkg::COEF_PLUS:  acc_sum = acc_base + lcs_pkg::AccW'(rnd);
            lcs_pkg::COEF_MINUS: acc_sum = acc_base - lcs_pkg::AccW'(rnd);
            default:             acc_sum = acc_base;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        dir_next   = dir_reg;
        right_next = right_reg;
        crs_next   = crs_reg;
        acc_next   = acc_reg;
        head_next  = head_reg;
        first_next = first_reg;
        dg_next    = dg_reg;
        cnt_next   = cnt_reg;
        axis_next  = axis_reg;
        mval_next  = mval_reg;
        mdata_next = mdata_reg;
        muser_next = muser_reg;
        if (mval_reg && m_tready) mval_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    head_next = s_tdata[3:0];
                    if (s_tuser) begin
                        pos_next[0] = s_tdata[35:4];
                        pos_next[1] = s_tdata[67:36];
                        pos_next[2] = s_tdata[99:68];
                        first_next  = 1'b0;
                    end else begin
                        first_next  = (s_tdata[3:0] < lcs_pkg::HeadCount);
                    end
                    state_next = ST_DIR_GO;
                end
            end
            ST_DIR_GO: state_next = ST_DIR_WAIT;
            ST_DIR_WAIT: begin
                if (u_stat.done) begin
                    dir_next   = u_vout;
                    dg_next    = u_stat.degen;
                    cnt_next   = '0;
                    state_next = ST_CROSS;
                end
            end
            ST_CROSS: begin
                if (!cnt_reg[0]) crs_next[cnt_reg[2:1]] = prod[lcs_pkg::CrsW-1:0];
                else crs_next[cnt_reg[2:1]] = crs_reg[cnt_reg[2:1]] - prod[lcs_pkg::CrsW-1:0];
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd5) state_next = ST_RIGHT_GO;
            end
            ST_RIGHT_GO: state_next = ST_RIGHT_WAIT;
            ST_RIGHT_WAIT: begin
                if (u_stat.done) begin
                    right_next = u_vout;
                    dg_next    = dg_reg | u_stat.degen;
                    cnt_next   = '0;
                    axis_next  = '0;
                    state_next = first_reg ? ST_MOVE : ST_FINISH;
                end
            end
            ST_MOVE: begin
                // three terms per axis, then saturate into the position
                acc_next = acc_sum;
                if (cnt_reg == 3'd2) begin
                    if (acc_sum > 34'sh07FFFFFFF)
                        pos_next[axis_reg] = 32'sh7FFFFFFF;
                    else if (acc_sum < -34'sh080000000)
                        pos_next[axis_reg] = 32'sh80000000;
                    else
                        pos_next[axis_reg] = acc_sum[31:0];
                    cnt_next = '0;
                    if (axis_reg == 2'd2) begin
                        first_next = 1'b0;
                        state_next = ST_DIR_GO;
                    end else begin
                        axis_next = axis_reg + 2'd1;
                    end
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            ST_FINISH: begin
                if (!mval_reg || m_tready) begin
                    mdata_next = {4'd0, right_reg[2], right_reg[1], right_reg[0],
                                  dir_reg[2], dir_reg[1], dir_reg[0],
                                  pos_reg[2], pos_reg[1], pos_reg[0]};
                    muser_next = dg_reg;
                    mval_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg   <= '{default: '0};
            first_reg <= 1'b0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            first_reg <= first_next;
            mval_reg  <= mval_next;
        end
        dir_reg   <= dir_next;
        right_reg <= right_next;
        crs_reg   <= crs_next;
        acc_reg   <= acc_next;
        head_reg  <= head_next;
        dg_reg    <= dg_next;
        cnt_reg   <= cnt_next;
        axis_reg  <= axis_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

`ifndef SYNTH
    a_unit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !u_stat.busy)
        else $error("normalizer busy while idle");
    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        u_stat.done |-> (state_reg == ST_DIR_WAIT || state_reg == ST_RIGHT_WAIT))
        else $error("normalizer result with nobody waiting");
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken during work");
    a_move_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MOVE) |-> first_reg)
        else $error("move outside first frame");
`endif

endmodule
